>>> src/ical_datetime_to_epoch_defines.svh
// ----------------------------------------------------------------------------
// ical_datetime_to_epoch_defines.svh
// Assertion macros shared by the date-time to epoch converter.
// ----------------------------------------------------------------------------
`ifndef ICAL_DATETIME_TO_EPOCH_DEFINES_SVH
`define ICAL_DATETIME_TO_EPOCH_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define ICDTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ICDTE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICDTE_ASSERT(lbl, prop, msg)
`define ICDTE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> src/icdte_pkg.sv
// ----------------------------------------------------------------------------
// icdte_pkg
// Types, character codes and small tables for the date-time converter.
// ----------------------------------------------------------------------------
package icdte_pkg;

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [11:0] LEAPS_1969  = 12'd477;
  localparam logic [22:0] DAYS_YEAR   = 23'd365;
  localparam logic [18:0] SEC_HOUR    = 19'd3600;
  localparam logic [18:0] SEC_MINUTE  = 19'd60;
  localparam logic signed [38:0] SEC_DAY = 39'sd86400;

  // Parsed fields of one value, flags already decided.
  typedef struct packed {
    logic        ok;
    logic        all_day;
    logic        floating;
    logic [13:0] year;
    logic [6:0]  cent;
    logic [6:0]  yy;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } date_fields_t;

  // Day count and time of day, ready for the final scale.
  typedef struct packed {
    logic               ok;
    logic               all_day;
    logic               floating;
    logic signed [23:0] days;
    logic [18:0]        tod;
  } day_count_t;

  function automatic logic [6:0] acc7_step(input logic [6:0] acc, input logic [3:0] dig);
    logic [10:0] t;
    t = {4'b0, acc} * 11'd10 + {7'b0, dig};
    return t[6:0];
  endfunction

  function automatic logic [13:0] acc14_step(input logic [13:0] acc,
                                             input logic [3:0] dig);
    logic [17:0] t;
    t = {4'b0, acc} * 18'd10 + {14'b0, dig};
    return t[13:0];
  endfunction

  // Days before the first of the month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/icdte_scan.sv
// ----------------------------------------------------------------------------
// icdte_scan
// Byte scanner: accumulates decimal fields and captures them on the last byte.
// ----------------------------------------------------------------------------
`include "ical_datetime_to_epoch_defines.svh"

module icdte_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   valid,
  output logic                   stall,
  input  logic [7:0]             value_byte,
  input  logic                   last_byte,
  input  logic                   date_only,
  input  logic                   has_tzid,
  output logic                   snap_valid,
  input  logic                   snap_stall,
  output icdte_pkg::date_fields_t snap
);
  import icdte_pkg::*;

  logic [4:0]  position;
  logic [13:0] year_acc;
  logic [6:0]  cent_acc, yy_acc, month_acc, day_acc, hour_acc, minute_acc, second_acc;
  logic        date_bad, time_bad;

  logic [4:0]  position_next;
  logic [13:0] year_next;
  logic [6:0]  cent_next, yy_next, month_next, day_next;
  logic [6:0]  hour_next, minute_next, second_next;
  logic        date_bad_next, time_bad_next;

  logic         accept, digit, month_ok, long_enough, exactly8, timed_len;
  logic         res_ok, res_all_day;
  logic [3:0]   dval;
  date_fields_t snap_next;

  assign stall  = snap_valid && snap_stall;
  assign accept = valid && !stall;

  always_comb begin
    digit         = value_byte inside {[CHAR_0:CHAR_9]};
    dval          = value_byte[3:0];
    year_next     = year_acc;
    cent_next     = cent_acc;
    yy_next       = yy_acc;
    month_next    = month_acc;
    day_next      = day_acc;
    hour_next     = hour_acc;
    minute_next   = minute_acc;
    second_next   = second_acc;
    date_bad_next = date_bad;
    time_bad_next = time_bad;
    case (position) inside
      [5'd0:5'd7]:  if (!digit) date_bad_next = 1'b1;
      5'd8:         if (value_byte != CHAR_T) time_bad_next = 1'b1;
      [5'd9:5'd14]: if (!digit) time_bad_next = 1'b1;
      default: ;
    endcase
    if (digit) begin
      case (position) inside
        [5'd0:5'd1]: begin
          year_next = acc14_step(year_acc, dval);
          cent_next = acc7_step(cent_acc, dval);
        end
        [5'd2:5'd3]: begin
          year_next = acc14_step(year_acc, dval);
          yy_next   = acc7_step(yy_acc, dval);
        end
        [5'd4:5'd5]:   month_next  = acc7_step(month_acc, dval);
        [5'd6:5'd7]:   day_next    = acc7_step(day_acc, dval);
        [5'd9:5'd10]:  hour_next   = acc7_step(hour_acc, dval);
        [5'd11:5'd12]: minute_next = acc7_step(minute_acc, dval);
        [5'd13:5'd14]: second_next = acc7_step(second_acc, dval);
        default: ;
      endcase
    end
    position_next = (position == 5'd31) ? position : position + 5'd1;

    long_enough = position >= 5'd7;
    exactly8    = position == 5'd7;
    timed_len   = position >= 5'd14;
    month_ok    = (month_next >= 7'd1) && (month_next <= 7'd12);
    res_ok      = long_enough && !date_bad_next && month_ok &&
                  (date_only || exactly8 || (timed_len && !time_bad_next));
    res_all_day = res_ok && (date_only || exactly8);

    snap_next.ok       = res_ok;
    snap_next.all_day  = res_all_day;
    snap_next.floating = has_tzid || (res_ok && !res_all_day && value_byte != CHAR_Z);
    snap_next.year     = year_next;
    snap_next.cent     = cent_next;
    snap_next.yy       = yy_next;
    snap_next.month    = month_next[3:0];
    snap_next.day      = day_next;
    snap_next.hour     = res_all_day ? 7'd0 : hour_next;
    snap_next.minute   = res_all_day ? 7'd0 : minute_next;
    snap_next.second   = res_all_day ? 7'd0 : second_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      year_acc   <= '0;
      cent_acc   <= '0;
      yy_acc     <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
      date_bad   <= 1'b0;
      time_bad   <= 1'b0;
      snap_valid <= 1'b0;
    end else begin
      if (accept && last_byte) begin
        position   <= '0;
        year_acc   <= '0;
        cent_acc   <= '0;
        yy_acc     <= '0;
        month_acc  <= '0;
        day_acc    <= '0;
        hour_acc   <= '0;
        minute_acc <= '0;
        second_acc <= '0;
        date_bad   <= 1'b0;
        time_bad   <= 1'b0;
      end else if (accept) begin
        position   <= position_next;
        year_acc   <= year_next;
        cent_acc   <= cent_next;
        yy_acc     <= yy_next;
        month_acc  <= month_next;
        day_acc    <= day_next;
        hour_acc   <= hour_next;
        minute_acc <= minute_next;
        second_acc <= second_next;
        date_bad   <= date_bad_next;
        time_bad   <= time_bad_next;
      end
      if (accept && last_byte) begin
        snap_valid <= 1'b1;
      end else if (!snap_stall) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap <= snap_next;
    end
  end

  `ICDTE_ASSERT(a_clear_after_last, accept && last_byte |=> position == 5'd0 && !date_bad && !time_bad, "scan state not cleared after last byte")
  `ICDTE_ASSERT(a_snap_from_last, $rose(snap_valid) |-> $past(accept && last_byte), "capture without a last byte")

endmodule

>>> src/icdte_calc.sv
// ----------------------------------------------------------------------------
// icdte_calc
// Day count since 1970 and time of day from the parsed fields.
// ----------------------------------------------------------------------------
module icdte_calc (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  icdte_pkg::date_fields_t fields,
  output logic                   calc_valid,
  input  logic                   calc_stall,
  output icdte_pkg::day_count_t  calc
);
  import icdte_pkg::*;

  logic        after_epoch, leap, leap_adj;
  logic [13:0] yd;
  logic [22:0] y365, dby;
  logic [6:0]  c1, y1;
  logic [11:0] leaps;
  logic [23:0] days_u;
  day_count_t  calc_next;

  assign in_stall = calc_valid && calc_stall;

  always_comb begin
    after_epoch = fields.year > EPOCH_YEAR;
    yd          = fields.year - EPOCH_YEAR;
    y365        = {9'b0, yd} * DAYS_YEAR;
    // Split year-1 into century and year of century.
    c1          = (fields.yy == 7'd0) ? fields.cent - 7'd1 : fields.cent;
    y1          = (fields.yy == 7'd0) ? 7'd99 : fields.yy - 7'd1;
    leaps       = {5'b0, c1} * 12'd24 + {7'b0, c1[6:2]} + {7'b0, y1[6:2]};
    dby         = after_epoch ? y365 + {11'b0, leaps} - {11'b0, LEAPS_1969} : 23'd0;
    leap        = ((fields.yy[1:0] == 2'd0) && (fields.yy != 7'd0)) ||
                  ((fields.yy == 7'd0) && (fields.cent[1:0] == 2'd0));
    leap_adj    = leap && (fields.month > 4'd2);
    days_u      = {1'b0, dby} + {15'b0, month_start(fields.month)} + {23'b0, leap_adj} +
                  {17'b0, fields.day} - 24'd1;

    calc_next.ok       = fields.ok;
    calc_next.all_day  = fields.all_day;
    calc_next.floating = fields.floating;
    calc_next.days     = $signed(days_u);
    calc_next.tod      = {12'b0, fields.hour} * SEC_HOUR + {12'b0, fields.minute} * SEC_MINUTE +
                         {12'b0, fields.second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_valid <= 1'b0;
    end else if (!in_stall) begin
      calc_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      calc <= calc_next;
    end
  end

endmodule

>>> src/icdte_out.sv
// ----------------------------------------------------------------------------
// icdte_out
// Scale days to seconds, add time of day, hold the result for the receiver.
// ----------------------------------------------------------------------------
module icdte_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  icdte_pkg::day_count_t calc,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  ok,
  output logic                  all_day,
  output logic                  floating,
  output logic signed [38:0]    epoch_seconds
);
  import icdte_pkg::*;

  logic signed [38:0] days_ext, secs;

  assign in_stall = rsp_valid && rsp_stall;

  always_comb begin
    days_ext = {{15{calc.days[23]}}, calc.days};
    secs     = calc.ok ? days_ext * SEC_DAY + $signed({20'b0, calc.tod}) : 39'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!in_stall) begin
      rsp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ok            <= calc.ok;
      all_day       <= calc.all_day;
      floating      <= calc.floating;
      epoch_seconds <= secs;
    end
  end

endmodule

>>> src/ical_datetime_to_epoch.sv
// ----------------------------------------------------------------------------
// ical_datetime_to_epoch
// iCalendar DATE / DATE-TIME text to signed seconds since 1970-01-01.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one byte of the value per
//   request, with last_byte marking the final byte; date_only and has_tzid
//   are sampled on that last byte. Only the last byte of a value produces a
//   response; every other byte just advances the field scanner.
//   Response channel (rsp_valid / rsp_stall) carries ok, all_day, floating
//   and epoch_seconds. A rejected value gives ok low and zero seconds.
// Timing:
//   One byte per cycle, sustained while req_stall is low, with no gaps
//   between values. A value's result passes three registered stages after
//   its last byte: scan capture, day count, then the multiply-by-86400 output.
//   Each stage holds its data while the one after it is stalled, so a stalled
//   receiver backs up through the stages and finally raises req_stall only
//   when all three are full.
// Reset:
//   Synchronous, active high. Clears the scanner and drops every pending
//   response; the next byte accepted is taken as position 0 of a new value.
// ----------------------------------------------------------------------------
`include "ical_datetime_to_epoch_defines.svh"

module ical_datetime_to_epoch (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [7:0]         value_byte,
  input  logic               last_byte,
  input  logic               date_only,
  input  logic               has_tzid,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               ok,
  output logic               all_day,
  output logic               floating,
  output logic signed [38:0] epoch_seconds
);
  import icdte_pkg::*;

  // Captured fields of a finished value, and its day count.
  date_fields_t snap;
  day_count_t   calc;
  logic         snap_valid, snap_stall;
  logic         calc_valid, calc_stall;

  // Scan bytes; capture the fields on the last one.
  icdte_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .valid      (req_valid),
    .stall      (req_stall),
    .value_byte (value_byte),
    .last_byte  (last_byte),
    .date_only  (date_only),
    .has_tzid   (has_tzid),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap)
  );

  // Reduce date to days since 1970, time to seconds of day.
  icdte_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (snap_valid),
    .in_stall   (snap_stall),
    .fields     (snap),
    .calc_valid (calc_valid),
    .calc_stall (calc_stall),
    .calc       (calc)
  );

  // Scale and hold the response.
  icdte_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (calc_valid),
    .in_stall      (calc_stall),
    .calc          (calc),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .ok            (ok),
    .all_day       (all_day),
    .floating      (floating),
    .epoch_seconds (epoch_seconds)
  );

  `ICDTE_ASSERT(a_reject_zero, rsp_valid && !ok |-> epoch_seconds == 39'sd0 && !all_day, "rejected value carries data")
  `ICDTE_ASSERT(a_all_day_ok, rsp_valid && all_day |-> ok, "all-day flag on a rejected value")
  `ICDTE_ASSERT_RST(a_reset_idle, rst |=> !rsp_valid, "response pending after reset")

endmodule
